/* rtl/scc_pkg.sv */
`default_nettype none
package scc_pkg;

  localparam int NUM_GAPS = 15;
  localparam int CFG_WIDTH = 30;

  typedef enum logic [1:0] {
    CFG_TERM_COUNT = 2'd0,
    CFG_OPERATORS  = 2'd1,
    CFG_NEGATE     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TS_UNKNOWN    = 2'd0,
    TS_FALSE      = 2'd1,
    TS_TRUE       = 2'd2,
    TS_NOT_NEEDED = 2'd3
  } term_state_t;

  typedef enum logic [1:0] {
    OP_AND   = 2'd0,
    OP_OR    = 2'd1,
    OP_XOR   = 2'd2,
    OP_LPAND = 2'd3
  } gap_op_t;

  // scan mode: evaluating a chunk, killing the rest of a failed chunk,
  // or skipping the rest of a group already known true
  typedef enum logic [1:0] {
    MODE_EVAL = 2'd0,
    MODE_KILL = 2'd1,
    MODE_SKIP = 2'd2
  } scan_mode_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_START  = 2'd1,
    FSM_SCAN   = 2'd2,
    FSM_FINISH = 2'd3
  } fsm_state_t;

  typedef struct packed {
    logic       mark;
    logic       stop;
    logic       det;
    logic       val;
    scan_mode_t mode_next;
  } step_t;

  function automatic logic truthy(term_state_t s);
    return (s == TS_TRUE) || (s == TS_NOT_NEEDED);
  endfunction

endpackage
`default_nettype wire

/* rtl/scc_item_if.sv */
`default_nettype none
interface scc_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] term_index;
  logic       term_value;

  modport source (output valid, op, term_index, term_value, input ready);
  modport sink (input valid, op, term_index, term_value, output ready);
endinterface
`default_nettype wire

/* rtl/scc_result_if.sv */
`default_nettype none
interface scc_result_if;
  logic        valid;
  logic        ready;
  logic        determined;
  logic        value;
  logic        bad_expression;
  logic [15:0] needed_mask;

  modport source (output valid, determined, value, bad_expression, needed_mask,
                  input ready);
  modport sink (input valid, determined, value, bad_expression, needed_mask,
                output ready);
endinterface
`default_nettype wire

/* rtl/short_circuit_logic_combiner.sv */
`default_nettype none
// Flow: an item is taken in IDLE; START settles one or two terms, a bad expression or an
//   unknown first term, three or more terms go to SCAN (one scan step a term), then FINISH.
// Items: the term scan runs through the single shared step unit; a new item is taken
//   only in idle, so no new item is taken before the last result is loaded.
// Reset (synchronous, rst high): registers to reset values, all terms unknown,
//   no result pending.
module short_circuit_logic_combiner #(
  parameter int MAX_TERMS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire [1:0]                      cfg_index,
  input  wire [scc_pkg::CFG_WIDTH-1:0]   cfg_data,
  scc_item_if.sink                       items,
  scc_result_if.source                   results
);

  localparam int CW = $clog2(MAX_TERMS);      // term pointer width
  localparam int NW = $clog2(MAX_TERMS + 1);  // term count width

  // configuration registers
  logic [4:0]  term_count;
  logic [29:0] operator_codes;
  logic [15:0] negate_mask;

  // term store: one 2-bit state per term, read by the scan pointer
  scc_pkg::term_state_t term_states [MAX_TERMS];

  // sequencer
  scc_pkg::fsm_state_t state, state_next;
  scc_pkg::scan_mode_t mode, mode_next;
  logic [CW-1:0]       k, k_next;
  logic                det, det_next;
  logic                val, val_next;
  logic                bad, bad_next;

  // term store write controls
  logic          clear_we;
  logic          rec_we;
  logic          mark_we;
  logic [CW-1:0] mark_idx;
  logic [CW-1:0] widx;
  logic          rec_bit;

  logic [NW-1:0]        n_act;
  logic                 last;
  logic [4:0]           kx;
  scc_pkg::gap_op_t     gap_cur;
  scc_pkg::gap_op_t     gap0;
  logic                 bad_c;
  scc_pkg::term_state_t st_cur;
  scc_pkg::term_state_t st_a;
  scc_pkg::term_state_t st_b;
  scc_pkg::step_t       step;
  logic [15:0]          mask_c;
  logic                 load;

  // output register
  logic        res_valid;
  logic        res_det;
  logic        res_val;
  logic        res_bad;
  logic [15:0] res_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count     <= 5'd1;
      operator_codes <= '0;
      negate_mask    <= '0;
    end else if (cfg_we) begin
      case (scc_pkg::cfg_reg_t'(cfg_index))
        scc_pkg::CFG_TERM_COUNT: term_count     <= cfg_data[4:0];
        scc_pkg::CFG_OPERATORS:  operator_codes <= cfg_data[29:0];
        scc_pkg::CFG_NEGATE:     negate_mask    <= cfg_data[15:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // active term count: zero reads as one, saturates at MAX_TERMS
  always_comb begin
    if (term_count == 5'd0) begin
      n_act = NW'(1);
    end else if (int'(term_count) > MAX_TERMS) begin
      n_act = NW'(MAX_TERMS);
    end else begin
      n_act = NW'(term_count);
    end
  end

  // gap code at the scan pointer; gaps beyond the register read as and
  assign kx      = 5'(k);
  assign gap_cur = (kx < 5'(scc_pkg::NUM_GAPS)) ?
                   scc_pkg::gap_op_t'(operator_codes[{kx[3:0], 1'b0} +: 2]) :
                   scc_pkg::OP_AND;
  assign gap0    = scc_pkg::gap_op_t'(operator_codes[1:0]);
  assign last    = (int'(k) == int'(n_act) - 1);

  // xor in any used gap of a three-or-more term expression
  always_comb begin
    bad_c = 1'b0;
    for (int g = 0; g < scc_pkg::NUM_GAPS; g++) begin
      if ((g < int'(n_act) - 1) && (operator_codes[2*g +: 2] == scc_pkg::OP_XOR)) begin
        bad_c = 1'b1;
      end
    end
    if (int'(n_act) < 3) begin
      bad_c = 1'b0;
    end
  end

  assign st_cur  = term_states[k];
  assign st_a    = term_states[0];
  assign st_b    = term_states[1];
  assign widx    = CW'(items.term_index);
  assign rec_bit = items.term_value ^ negate_mask[items.term_index];

  scc_step u_step (
    .mode  (mode),
    .state (st_cur),
    .last  (last),
    .gap   (gap_cur),
    .step  (step)
  );

  assign items.ready = (state == scc_pkg::FSM_IDLE);

  // sequencer: next state and controls
  always_comb begin
    state_next = state;
    mode_next  = mode;
    k_next     = k;
    det_next   = det;
    val_next   = val;
    bad_next   = bad;
    clear_we   = 1'b0;
    rec_we     = 1'b0;
    mark_we    = 1'b0;
    mark_idx   = k;
    load       = 1'b0;
    case (state)
      scc_pkg::FSM_IDLE: begin
        if (items.valid) begin
          if (!items.op) begin
            clear_we = 1'b1;
          end else if ((int'(items.term_index) < int'(n_act)) &&
                       (term_states[widx] == scc_pkg::TS_UNKNOWN)) begin
            rec_we = 1'b1;  // first result for this term only
          end
          state_next = scc_pkg::FSM_START;
        end
      end
      scc_pkg::FSM_START: begin
        k_next     = '0;
        mode_next  = scc_pkg::MODE_EVAL;
        bad_next   = bad_c;
        det_next   = 1'b0;
        val_next   = 1'b0;
        state_next = scc_pkg::FSM_FINISH;
        if (!bad_c && (st_a != scc_pkg::TS_UNKNOWN)) begin
          if (n_act == NW'(1)) begin
            det_next = 1'b1;
            val_next = scc_pkg::truthy(st_a);
          end else if (n_act == NW'(2)) begin
            if (gap0 == scc_pkg::OP_OR) begin
              if (st_b == scc_pkg::TS_UNKNOWN) begin
                if (scc_pkg::truthy(st_a)) begin
                  // true left side: right side no longer needed
                  mark_we  = 1'b1;
                  mark_idx = CW'(1);
                  det_next = 1'b1;
                  val_next = 1'b1;
                end
              end else begin
                det_next = 1'b1;
                val_next = scc_pkg::truthy(st_a) | scc_pkg::truthy(st_b);
              end
            end else if (st_b != scc_pkg::TS_UNKNOWN) begin
              det_next = 1'b1;
              if (gap0 == scc_pkg::OP_XOR) begin
                val_next = scc_pkg::truthy(st_a) ^ scc_pkg::truthy(st_b);
              end else begin
                val_next = scc_pkg::truthy(st_a) & scc_pkg::truthy(st_b);
              end
            end
          end else begin
            state_next = scc_pkg::FSM_SCAN;
          end
        end
      end
      scc_pkg::FSM_SCAN: begin
        mark_we = step.mark;
        if (step.stop) begin
          det_next   = step.det;
          val_next   = step.val;
          state_next = scc_pkg::FSM_FINISH;
        end else begin
          k_next    = k + CW'(1);
          mode_next = step.mode_next;
        end
      end
      scc_pkg::FSM_FINISH: begin
        if (!res_valid || results.ready) begin
          load       = 1'b1;
          state_next = scc_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = scc_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::FSM_IDLE;
      mode  <= scc_pkg::MODE_EVAL;
      k     <= '0;
      det   <= 1'b0;
      val   <= 1'b0;
      bad   <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      k     <= k_next;
      det   <= det_next;
      val   <= val_next;
      bad   <= bad_next;
    end
  end

  // term store: clear, record and scan marks never coincide
  always_ff @(posedge clk) begin
    if (rst || clear_we) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        term_states[i] <= scc_pkg::TS_UNKNOWN;
      end
    end else if (rec_we) begin
      term_states[widx] <= rec_bit ? scc_pkg::TS_TRUE : scc_pkg::TS_FALSE;
    end else if (mark_we) begin
      term_states[mark_idx] <= scc_pkg::TS_NOT_NEEDED;
    end
  end

  // still-unknown terms after the scan
  for (genvar i = 0; i < 16; i++) begin : g_mask
    if (i < MAX_TERMS) begin : g_on
      assign mask_c[i] = (i < int'(n_act)) && (term_states[i] == scc_pkg::TS_UNKNOWN);
    end else begin : g_off
      assign mask_c[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_det  <= det;
      res_val  <= det & val;
      res_bad  <= bad;
      res_mask <= mask_c;
    end
  end

  assign results.valid          = res_valid;
  assign results.determined     = res_det;
  assign results.value          = res_val;
  assign results.bad_expression = res_bad;
  assign results.needed_mask    = res_mask;

endmodule
`default_nettype wire

/* rtl/scc_step.sv */
`default_nettype none
// One term of the left-to-right short-circuit scan.
module scc_step (
  input  wire scc_pkg::scan_mode_t  mode,
  input  wire scc_pkg::term_state_t state,
  input  wire                       last,
  input  wire scc_pkg::gap_op_t     gap,
  output scc_pkg::step_t            step
);

  logic chunk_false;

  always_comb begin
    step = '{mark: 1'b0, stop: 1'b0, det: 1'b0, val: 1'b0,
             mode_next: scc_pkg::MODE_EVAL};
    chunk_false = (mode == scc_pkg::MODE_KILL) ||
                  ((mode == scc_pkg::MODE_EVAL) && (state == scc_pkg::TS_FALSE));
    step.mark = (mode == scc_pkg::MODE_KILL);
    case (mode)
      scc_pkg::MODE_SKIP: begin
        if (last) begin
          step.stop = 1'b1;
          step.det  = 1'b1;
          step.val  = 1'b1;
        end else if (gap == scc_pkg::OP_LPAND) begin
          step.mode_next = scc_pkg::MODE_EVAL;
        end else begin
          step.mode_next = scc_pkg::MODE_SKIP;
        end
      end
      default: begin
        if ((mode == scc_pkg::MODE_EVAL) && (state == scc_pkg::TS_UNKNOWN)) begin
          step.stop = 1'b1;  // undetermined, stop without further marks
        end else if (chunk_false) begin
          if (!last && (gap == scc_pkg::OP_AND)) begin
            step.mode_next = scc_pkg::MODE_KILL;
          end else if (last || (gap == scc_pkg::OP_LPAND)) begin
            step.stop = 1'b1;
            step.det  = 1'b1;
          end else begin
            step.mode_next = scc_pkg::MODE_EVAL;  // next chunk of the OR group
          end
        end else begin
          if (last) begin
            step.stop = 1'b1;
            step.det  = 1'b1;
            step.val  = 1'b1;
          end else if (gap == scc_pkg::OP_OR) begin
            step.mode_next = scc_pkg::MODE_SKIP;  // group already true
          end else begin
            step.mode_next = scc_pkg::MODE_EVAL;
          end
        end
      end
    endcase
  end

endmodule
`default_nettype wire
